[sv/pssl_pkg.sv]
// ----------------------------------------------------------------------------
// pssl_pkg: shared types and constants of the per-session request limiter
// Request and response payloads, configuration register indexes and reset
// values, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pssl_pkg;

	localparam int SID_W      = 32;
	localparam int TIME_W     = 48;
	localparam int WIN_W      = 32;
	localparam int MAXREQ_W   = 5;
	localparam int CNT_OUT_W  = 5;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUESTS = 1'b1;

	// configuration reset values
	localparam logic [WIN_W-1:0]    WINDOW_RESET = 32'd60000;
	localparam logic [MAXREQ_W-1:0] MAXREQ_RESET = 5'd10;

	typedef struct packed {
		logic [SID_W-1:0]  session_id;
		logic [TIME_W-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic                 limited;
		logic                 table_full;
		logic [CNT_OUT_W-1:0] recent_count;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load_req;   // capture the accepted request
		logic e_clr;      // entry counter to zero
		logic e_inc;      // entry counter advance
		logic j_clr;      // slot counter to zero, clear count and free search
		logic j_inc;      // slot counter advance
		logic mask_take;  // load live mask from the entry word
		logic mask_zero;  // empty live mask (entry taken over)
		logic upd_step;   // drop expired slot, count, look for free slot
		logic commit;     // write back entry and slot, load response
		logic res_full;   // load table-full response
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;     // current entry is used and holds the session
		logic used;    // current entry is used
		logic e_last;  // entry counter at last entry
		logic j_last;  // slot counter at last slot
		logic alive;   // current slot is live and not expired
	} sts_t;

endpackage

[sv/per_session_sliding_window_limiter.sv]
// ----------------------------------------------------------------------------
// per_session_sliding_window_limiter: per-session sliding-window rate limiter
// A request (session_id, now_ms) enters on the req channel, valid/ready; one
// response (limited, table_full, recent_count) leaves on the rsp channel.
// cfg_we/cfg_index/cfg_data write window_ms (index 0) and max_requests
// (index 1); write them only while no request is in flight.
// Each request is one transfer in and one transfer out; req_ready is high
// only between requests. The entry memory and the slot memory are scanned
// one word per cycle: a session found in entry k is matched once entries 0
// to k are read, and its row of slots is then updated and written back. A
// new session first scans all SESSIONS entries, then checks entries in order
// and takes the first that is unused or whose slots have all expired; a used
// entry is read slot by slot and passed over at its first live slot. The
// slot update follows; a full table answers after that search.
// Reset clears the used flags of all entries and restores the register
// defaults; memory contents need no clearing pass.
// A finished response sits in an output register; while the receiver
// stalls, the next request is still taken and processed, and waits at write
// back until the output register frees.
// ----------------------------------------------------------------------------
module per_session_sliding_window_limiter #(
	parameter int SESSIONS = 16,
	parameter int SLOTS    = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  pssl_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output pssl_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic [pssl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pssl_pkg::CFG_DATA_W-1:0] cfg_data
);

	pssl_pkg::cmd_t cmd;
	pssl_pkg::sts_t sts;

	// sequencer
	pssl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// memories, compare and response
	pssl_dp #(
		.SESSIONS (SESSIONS),
		.SLOTS    (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

[sv/pssl_ram.sv]
// ----------------------------------------------------------------------------
// pssl_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pssl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[sv/pssl_ctrl.sv]
// ----------------------------------------------------------------------------
// pssl_ctrl: request sequencer of the per-session limiter
// Walks a request through session match, entry allocation, slot update and
// write back, and owns the response valid flag.
// ----------------------------------------------------------------------------
module pssl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  pssl_pkg::sts_t sts,
	output pssl_pkg::cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_MATCH   = 7'b0000010,
		ST_ALLOC_E = 7'b0000100,
		ST_ALLOC_S = 7'b0001000,
		ST_UPD     = 7'b0010000,
		ST_COMMIT  = 7'b0100000,
		ST_FULL    = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					cmd.e_clr    = 1'b1;
					state_d      = ST_MATCH;
				end
			end
			ST_MATCH: begin
				if (sts.hit) begin
					cmd.mask_take = 1'b1;
					cmd.j_clr     = 1'b1;
					state_d       = ST_UPD;
				end else if (sts.e_last) begin
					cmd.e_clr = 1'b1;
					state_d   = ST_ALLOC_E;
				end else begin
					cmd.e_inc = 1'b1;
				end
			end
			ST_ALLOC_E: begin
				cmd.j_clr = 1'b1;
				if (!sts.used) begin
					cmd.mask_zero = 1'b1;
					state_d       = ST_UPD;
				end else begin
					cmd.mask_take = 1'b1;
					state_d       = ST_ALLOC_S;
				end
			end
			ST_ALLOC_S: begin
				if (sts.alive) begin
					// entry still counts a request: try the next one
					if (sts.e_last) begin
						state_d = ST_FULL;
					end else begin
						cmd.e_inc = 1'b1;
						state_d   = ST_ALLOC_E;
					end
				end else if (sts.j_last) begin
					cmd.mask_zero = 1'b1;
					cmd.j_clr     = 1'b1;
					state_d       = ST_UPD;
				end else begin
					cmd.j_inc = 1'b1;
				end
			end
			ST_UPD: begin
				cmd.upd_step = 1'b1;
				if (sts.j_last) begin
					state_d = ST_COMMIT;
				end else begin
					cmd.j_inc = 1'b1;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_FULL: begin
				if (out_free) begin
					cmd.res_full = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the response until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.res_full) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_COMMIT || state_q == ST_FULL))
		else $error("response raised outside a finishing state");

endmodule

[sv/pssl_dp.sv]
// ----------------------------------------------------------------------------
// pssl_dp: datapath of the per-session limiter
// Configuration registers, request capture, entry and slot memories, scan
// counters, expiry compare, live mask update, limit check and response.
// ----------------------------------------------------------------------------
module pssl_dp #(
	parameter int SESSIONS = 16,
	parameter int SLOTS    = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pssl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pssl_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  pssl_pkg::req_t                      req,
	input  pssl_pkg::cmd_t                      cmd,
	output pssl_pkg::sts_t                      sts,
	output pssl_pkg::rsp_t                      rsp
);

	localparam int EW     = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
	localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW     = $clog2(SLOTS + 1);
	localparam int CMPW   = (CW > pssl_pkg::MAXREQ_W) ? CW : pssl_pkg::MAXREQ_W;
	localparam int ENT_W  = pssl_pkg::SID_W + SLOTS;
	localparam int SDEPTH = SESSIONS * (2 ** SW);
	localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
	localparam int TW     = pssl_pkg::TIME_W;

	logic [pssl_pkg::WIN_W-1:0]    window_q;
	logic [pssl_pkg::MAXREQ_W-1:0] max_req_q;
	logic [pssl_pkg::SID_W-1:0]    sid_q;
	logic [TW-1:0]                 now_q;
	logic [EW-1:0]                 e_q, e_d;
	logic [SW-1:0]                 j_q, j_d;
	logic [SLOTS-1:0]              mask_q;
	logic [CW-1:0]                 count_q;
	logic [SW-1:0]                 free_q;
	logic                          free_found_q;
	logic [SESSIONS-1:0]           used_q;
	pssl_pkg::rsp_t                rsp_q;

	logic [ENT_W-1:0]              ent_rd;
	logic [pssl_pkg::SID_W-1:0]    ent_sid;
	logic [SLOTS-1:0]              ent_mask;
	logic [TW-1:0]                 slot_rd;
	logic [TW:0]                   age;
	logic                          expired;
	logic                          alive;
	logic                          admit;
	logic [SLOTS-1:0]              free_oh;
	logic [SLOTS-1:0]              mask_wr;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= pssl_pkg::WINDOW_RESET;
			max_req_q <= pssl_pkg::MAXREQ_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pssl_pkg::CFG_WINDOW_MS: begin
					window_q <= cfg_data[pssl_pkg::WIN_W-1:0];
				end
				pssl_pkg::CFG_MAX_REQUESTS: begin
					max_req_q <= cfg_data[pssl_pkg::MAXREQ_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// next counter values also address the memories, so read data always
	// matches the current counters
	always_comb begin
		e_d = e_q;
		if (cmd.e_clr) begin
			e_d = '0;
		end else if (cmd.e_inc) begin
			e_d = e_q + EW'(1);
		end
	end

	always_comb begin
		j_d = j_q;
		if (cmd.j_clr) begin
			j_d = '0;
		end else if (cmd.j_inc) begin
			j_d = j_q + SW'(1);
		end
	end

	// entry word: session id above the live mask
	pssl_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SESSIONS)
	) u_entry_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (e_q),
		.wdata ({sid_q, mask_wr}),
		.raddr (e_d),
		.rdata (ent_rd)
	);

	// request times, one row of slots per entry
	pssl_ram #(
		.WIDTH (TW),
		.DEPTH (SDEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (cmd.commit && admit),
		.waddr (SAW'({e_q, free_q})),
		.wdata (now_q),
		.raddr (SAW'({e_d, j_d})),
		.rdata (slot_rd)
	);

	assign ent_sid  = ent_rd[ENT_W-1 -: pssl_pkg::SID_W];
	assign ent_mask = ent_rd[SLOTS-1:0];

	// expiry: not in the future and older than the window
	assign age     = {1'b0, now_q} - {1'b0, slot_rd};
	assign expired = !age[TW] && (age[TW-1:0] > TW'(window_q));
	assign alive   = mask_q[j_q] && !expired;

	// limit is the smaller of max_requests and the slot count
	assign admit   = (CMPW'(count_q) < CMPW'(max_req_q)) && (count_q != CW'(SLOTS));
	assign free_oh = SLOTS'(1) << free_q;
	assign mask_wr = admit ? (mask_q | free_oh) : mask_q;

	assign sts.hit    = used_q[e_q] && (ent_sid == sid_q);
	assign sts.used   = used_q[e_q];
	assign sts.e_last = (e_q == EW'(SESSIONS - 1));
	assign sts.j_last = (j_q == SW'(SLOTS - 1));
	assign sts.alive  = alive;

	// capture request
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			sid_q <= req.session_id;
			now_q <= req.now_ms;
		end
	end

	// scan state: counters, live mask, count, free slot search, used bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q          <= '0;
			j_q          <= '0;
			mask_q       <= '0;
			count_q      <= '0;
			free_found_q <= 1'b0;
			used_q       <= '0;
		end else begin
			e_q <= e_d;
			j_q <= j_d;
			if (cmd.mask_take) begin
				mask_q <= ent_mask;
			end else if (cmd.mask_zero) begin
				mask_q <= '0;
			end else if (cmd.upd_step) begin
				mask_q[j_q] <= alive;
			end
			if (cmd.j_clr) begin
				count_q      <= '0;
				free_found_q <= 1'b0;
			end else if (cmd.upd_step) begin
				if (alive) begin
					count_q <= count_q + CW'(1);
				end else begin
					free_found_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				used_q[e_q] <= 1'b1;
			end
		end
	end

	// remember the first free slot
	always_ff @(posedge clk) begin
		if (cmd.upd_step && !alive && !free_found_q) begin
			free_q <= j_q;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.limited      <= !admit;
			rsp_q.table_full   <= 1'b0;
			rsp_q.recent_count <= pssl_pkg::CNT_OUT_W'(count_q);
		end else if (cmd.res_full) begin
			rsp_q.limited      <= 1'b1;
			rsp_q.table_full   <= 1'b1;
			rsp_q.recent_count <= '0;
		end
	end

	assign rsp = rsp_q;

	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && admit) |-> free_found_q)
		else $error("request admitted without a free slot");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOTS))
		else $error("live count above slot count");

	a_mask_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> ($countones(mask_q) == int'(count_q)))
		else $error("live mask disagrees with live count");

endmodule

[test/per_session_sliding_window_limiter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_session_sliding_window_limiter_test: self-checking bench of the limiter
// A directed table covers the reset settings, the time and id extremes, the
// window boundary, the full table, entry takeover, a zero window and a zero
// limit. Random phases follow, each with its own window, limit, session pool
// and time stride. Directed responses are checked against the table's expected
// values and random ones against an in-bench model of the session table, with
// random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module per_session_sliding_window_limiter_test;

	localparam int NSESS = 16;
	localparam int NSLOT = 16;

	typedef enum bit {ROW_ITEM, ROW_REGS} row_kind_t;

	typedef struct {
		row_kind_t      kind;
		pssl_pkg::req_t item;
		bit             typed;
		pssl_pkg::rsp_t want;
		logic [31:0]    win;
		logic [31:0]    maxr;
	} plan_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            req_valid;
	logic                            req_ready;
	pssl_pkg::req_t                  req;
	logic                            rsp_valid;
	logic                            rsp_ready = 1'b0;
	pssl_pkg::rsp_t                  rsp;
	logic                            cfg_we;
	logic [pssl_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pssl_pkg::CFG_DATA_W-1:0] cfg_data;

	// model of the session table and its settings
	bit [pssl_pkg::SID_W-1:0]    held_sid   [NSESS];
	bit                          held_used  [NSESS];
	bit [pssl_pkg::TIME_W-1:0]   stamp_at   [NSESS*NSLOT];
	bit                          stamp_live [NSESS*NSLOT];
	bit [pssl_pkg::WIN_W-1:0]    win_len = pssl_pkg::WINDOW_RESET;
	bit [pssl_pkg::MAXREQ_W-1:0] req_cap = pssl_pkg::MAXREQ_RESET;

	pssl_pkg::rsp_t verdicts_due [$];
	plan_row_t      plan [$];
	int             mismatches = 0;
	int             stall_left = 0;
	bit             calm = 1'b0;
	pssl_pkg::rsp_t due;

	per_session_sliding_window_limiter #(
		.SESSIONS(NSESS),
		.SLOTS   (NSLOT)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// a stored time counts until it is more than the window behind now
	function automatic bit is_stale(input bit [pssl_pkg::TIME_W-1:0] t,
			input bit [pssl_pkg::TIME_W-1:0] now);
		return (now >= t) &&
			((now - t) > {{(pssl_pkg::TIME_W-pssl_pkg::WIN_W){1'b0}}, win_len});
	endfunction

	function automatic bit all_stale(input int e, input bit [pssl_pkg::TIME_W-1:0] now);
		int j;
		for (j = 0; j < NSLOT; j++)
			if (stamp_live[e*NSLOT+j] && !is_stale(stamp_at[e*NSLOT+j], now))
				return 1'b0;
		return 1'b1;
	endfunction

	// find or take an entry, drop old stamps, then admit or refuse
	function automatic pssl_pkg::rsp_t judge_request(input pssl_pkg::req_t r);
		int             e, j, s, hit, cnt, cap;
		pssl_pkg::rsp_t v;
		v   = '0;
		hit = -1;
		cnt = 0;
		for (e = 0; e < NSESS && hit < 0; e++)
			if (held_used[e] && held_sid[e] == r.session_id)
				hit = e;
		if (hit < 0) begin
			for (e = 0; e < NSESS && hit < 0; e++)
				if (!held_used[e] || all_stale(e, r.now_ms))
					hit = e;
			if (hit < 0) begin
				v.limited    = 1'b1;
				v.table_full = 1'b1;
				return v;
			end
			held_used[hit] = 1'b1;
			held_sid[hit]  = r.session_id;
			for (j = 0; j < NSLOT; j++)
				stamp_live[hit*NSLOT+j] = 1'b0;
		end
		for (j = 0; j < NSLOT; j++) begin
			s = hit*NSLOT + j;
			if (stamp_live[s] && is_stale(stamp_at[s], r.now_ms))
				stamp_live[s] = 1'b0;
			if (stamp_live[s])
				cnt++;
		end
		cap = (req_cap > NSLOT) ? NSLOT : req_cap;
		v.recent_count = pssl_pkg::CNT_OUT_W'(cnt);
		if (cnt >= cap) begin
			v.limited = 1'b1;
			return v;
		end
		for (j = 0; j < NSLOT; j++) begin
			s = hit*NSLOT + j;
			if (!stamp_live[s]) begin
				stamp_live[s] = 1'b1;
				stamp_at[s]   = r.now_ms;
				break;
			end
		end
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void plan_req(input logic [pssl_pkg::SID_W-1:0] sid,
			input logic [pssl_pkg::TIME_W-1:0] now, input bit typed,
			input pssl_pkg::rsp_t want);
		plan_row_t row;
		row.kind            = ROW_ITEM;
		row.item.session_id = sid;
		row.item.now_ms     = now;
		row.typed           = typed;
		row.want            = want;
		row.win             = '0;
		row.maxr            = '0;
		plan.insert(plan.size(), row);
	endfunction

	function automatic void plan_regs(input logic [31:0] win, input logic [31:0] maxr);
		plan_row_t row;
		row.kind  = ROW_REGS;
		row.item  = '0;
		row.typed = 1'b0;
		row.want  = '0;
		row.win   = win;
		row.maxr  = maxr;
		plan.insert(plan.size(), row);
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0h, got %0h", what, want, got);
	endtask

	// present one request, hold it until the transfer, record its verdict
	task automatic drive_request(input pssl_pkg::req_t item, input bit typed,
			input pssl_pkg::rsp_t want);
		int             gap;
		pssl_pkg::rsp_t v;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		v = judge_request(item);
		verdicts_due.insert(verdicts_due.size(), typed ? want : v);
	endtask

	// drop valid and wait until every response is back
	task automatic finish_burst();
		req_valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_config(input logic [31:0] win, input logic [31:0] maxr);
		cfg_we    <= 1'b1;
		cfg_index <= pssl_pkg::CFG_WINDOW_MS;
		cfg_data  <= win;
		@(posedge clk);
		cfg_index <= pssl_pkg::CFG_MAX_REQUESTS;
		cfg_data  <= maxr;
		@(posedge clk);
		cfg_we  <= 1'b0;
		win_len = win;
		req_cap = maxr[pssl_pkg::MAXREQ_W-1:0];
	endtask

	// response side: check each transfer, then stall at random
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			if (verdicts_due.size() == 0) begin
				note_mismatch("response with none pending", '0, 32'(rsp));
			end else begin
				due = verdicts_due.pop_front();
				if (rsp.limited !== due.limited)
					note_mismatch("limited", 32'(due.limited), 32'(rsp.limited));
				if (rsp.table_full !== due.table_full)
					note_mismatch("table_full", 32'(due.table_full), 32'(rsp.table_full));
				if (rsp.recent_count !== due.recent_count)
					note_mismatch("recent_count", 32'(due.recent_count),
						32'(rsp.recent_count));
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if (calm || $urandom_range(0, 9) < 6) begin
			rsp_ready <= 1'b1;
		end else begin
			stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
			                                           : $urandom_range(0, 2);
			rsp_ready <= 1'b0;
		end
	end

	initial begin : stimulus
		int                          ph, k, i, r;
		logic [31:0]                 win, maxr, stride, tmp;
		logic [pssl_pkg::TIME_W-1:0] clock_ms;
		logic [pssl_pkg::SID_W-1:0]  last_sid;
		logic [pssl_pkg::SID_W-1:0]  pool [$];
		pssl_pkg::req_t              item;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;

		// reset settings: id and time extremes; the far future time ages out
		// the first stamp, so its entry is taken over
		plan_req(32'h0, 48'd0, 1'b1, '{1'b0, 1'b0, 5'd0});
		plan_req(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, '{1'b0, 1'b0, 5'd0});
		// stored time ahead of now never ages out
		plan_req(32'hFFFF_FFFF, 48'd5, 1'b1, '{1'b0, 1'b0, 5'd1});
		// exactly one window old still counts, one more ms drops it
		plan_req(32'h0, 48'd0, 1'b1, '{1'b0, 1'b0, 5'd0});
		plan_req(32'h0, 48'd60000, 1'b1, '{1'b0, 1'b0, 5'd1});
		plan_req(32'h0, 48'd60001, 1'b1, '{1'b0, 1'b0, 5'd1});
		// fill the remaining entries, then overflow the table
		for (i = 1; i <= 14; i++)
			plan_req(i, 48'd60001, 1'b1, '{1'b0, 1'b0, 5'd0});
		plan_req(32'd15, 48'd60001, 1'b1, '{1'b1, 1'b1, 5'd0});
		// entry whose stamps all aged out is taken over
		plan_req(32'd15, 48'd120002, 1'b1, '{1'b0, 1'b0, 5'd0});
		// zero window with a limit of two
		plan_regs(32'd0, 32'd2);
		plan_req(32'd7, 48'd200000, 1'b1, '{1'b0, 1'b0, 5'd0});
		plan_req(32'd7, 48'd200000, 1'b1, '{1'b0, 1'b0, 5'd1});
		plan_req(32'd7, 48'd200000, 1'b1, '{1'b1, 1'b0, 5'd2});
		plan_req(32'd7, 48'd200001, 1'b1, '{1'b0, 1'b0, 5'd0});
		// zero limit refuses everything
		plan_regs(32'd0, 32'd0);
		plan_req(32'd7, 48'd200001, 1'b1, '{1'b1, 1'b0, 5'd1});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		for (i = 0; i < plan.size(); i++) begin
			if (plan[i].kind == ROW_REGS) begin
				finish_burst();
				write_config(plan[i].win, plan[i].maxr);
			end else begin
				drive_request(plan[i].item, plan[i].typed, plan[i].want);
			end
		end
		finish_burst();

		// random phases, each with its own settings and session pool
		clock_ms = 48'd300000;
		for (ph = 0; ph < 10; ph++) begin
			calm = ($urandom_range(0, 3) == 0);
			if (ph == 0) begin
				win  = 32'hFFFF_FFFF;
				maxr = 32'd16;
			end else if (ph == 9) begin
				win  = 32'd1;
				maxr = 32'd31;
			end else begin
				r = $urandom_range(0, 7);
				case (r)
					0: win = 32'd0;
					1: win = 32'd1;
					2: win = $urandom_range(2, 20);
					3: win = $urandom_range(100, 5000);
					4: win = 32'd60000;
					5: win = 32'hFFFF_FFFF;
					default: win = $urandom;
				endcase
				r = $urandom_range(0, 9);
				if (r == 0)
					maxr = 32'd0;
				else if (r == 1)
					maxr = 32'd1;
				else if (r == 9)
					maxr = $urandom_range(17, 31);
				else
					maxr = $urandom_range(2, 16);
			end
			write_config(win, maxr);

			// session pool: sometimes small enough to hit the limit, sometimes
			// large enough to overflow the table
			pool.delete();
			case ($urandom_range(0, 3))
				0: r = 3;
				1: r = 8;
				2: r = 17;
				default: r = 30;
			endcase
			repeat (r) pool.insert(pool.size(), $urandom);
			pool[0] = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
			last_sid = pool[0];

			if ($urandom_range(0, 2) == 0) begin
				tmp      = $urandom;
				clock_ms = {tmp[15:0], $urandom()};
			end
			stride = (win < 4) ? 32'd3 : (win >> $urandom_range(1, 3));

			for (k = 0; k < 70; k++) begin
				// advance time, now and then step it back
				if ($urandom_range(0, 24) == 0)
					clock_ms = clock_ms - $urandom_range(0, stride);
				else if ($urandom_range(0, 9) >= 3)
					clock_ms = clock_ms + $urandom_range(0, stride);
				r = $urandom_range(0, 19);
				if (r == 0)
					last_sid = $urandom;
				else if (r < 10)
					last_sid = pool[$urandom_range(0, pool.size() - 1)];
				item.session_id = last_sid;
				item.now_ms     = clock_ms;
				drive_request(item, 1'b0, '0);
			end
			finish_burst();
		end

		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
